// ===== rtl/core/midpoint_subdivision_line_clipper_macros.svh =====
// Assertion macros used by the checker file.
`ifndef MIDPOINT_SUBDIVISION_LINE_CLIPPER_MACROS_SVH
`define MIDPOINT_SUBDIVISION_LINE_CLIPPER_MACROS_SVH

// Check a property outside reset.
`define MSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define MSC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/msc_pkg.sv =====
`default_nettype none
package msc_pkg;

   localparam int COORD_BITS_DEFAULT  = 11;
   localparam int COORD_BITS_MAX      = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int CSR_ADDR_BITS       = 4;
   localparam int CSR_DATA_BITS       = 32;

   typedef logic [COORD_BITS_MAX-1:0] coord_max_type;
   typedef logic [1:0]                pass_type;

   localparam pass_type PASS_FIRST = 2'd1;
   localparam pass_type PASS_LAST  = 2'd3;

   typedef enum logic [1:0] {
      REG_WIN_X_MIN = 2'd0,
      REG_WIN_X_MAX = 2'd1,
      REG_WIN_Y_MIN = 2'd2,
      REG_WIN_Y_MAX = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      SEG_ACCEPT,
      SEG_REJECT,
      SEG_CLIP
   } seg_class_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_CHECK,
      BACK_BISECT,
      BACK_EMIT
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      coord_max_type x_min;
      coord_max_type x_max;
      coord_max_type y_min;
      coord_max_type y_max;
   } window_type;

   // bit 3 left, bit 2 right, bit 1 below, bit 0 above
   function automatic logic [3:0] outcode(coord_max_type x, coord_max_type y, window_type win);
      outcode = {x < win.x_min, x > win.x_max, y < win.y_min, y > win.y_max};
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/msc_queue.sv =====
`default_nettype none
module msc_queue
   import msc_pkg::*;
#(
   parameter int WIDTH = 4 * COORD_BITS_DEFAULT + 2,
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output queue_status_type      status
);

   localparam int PTR_BITS   = $clog2(DEPTH);
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]      store_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign status.full  = (count_ff == COUNT_BITS'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/msc_front.sv =====
`default_nettype none
module msc_front
   import msc_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [COORD_BITS-1:0] req_start_x,
   input  wire logic [COORD_BITS-1:0] req_start_y,
   input  wire logic [COORD_BITS-1:0] req_end_x,
   input  wire logic [COORD_BITS-1:0] req_end_y,
   input  window_type                 window,
   input  queue_status_type           queue_status,
   output logic                       push,
   output logic [4*COORD_BITS+$bits(seg_class_type)-1:0] push_data
);

   logic [3:0]    code_a;
   logic [3:0]    code_b;
   seg_class_type seg_class;

   assign code_a = outcode(COORD_BITS_MAX'(req_start_x), COORD_BITS_MAX'(req_start_y), window);
   assign code_b = outcode(COORD_BITS_MAX'(req_end_x), COORD_BITS_MAX'(req_end_y), window);

   always_comb begin
      if (code_a == '0 && code_b == '0) begin
         seg_class = SEG_ACCEPT;
      end else if ((code_a & code_b) != '0) begin
         seg_class = SEG_REJECT;
      end else begin
         seg_class = SEG_CLIP;
      end
   end

   assign req_ready = !queue_status.full;
   assign push      = req_valid && !queue_status.full;
   assign push_data = {seg_class, req_start_x, req_start_y, req_end_x, req_end_y};

endmodule
`default_nettype wire

// ===== rtl/core/msc_back.sv =====
`default_nettype none
module msc_back
   import msc_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  window_type                 window,
   input  queue_status_type           queue_status,
   input  wire logic [4*COORD_BITS+$bits(seg_class_type)-1:0] pop_data,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_visible,
   output logic      [COORD_BITS-1:0] rsp_clip_ax,
   output logic      [COORD_BITS-1:0] rsp_clip_ay,
   output logic      [COORD_BITS-1:0] rsp_clip_bx,
   output logic      [COORD_BITS-1:0] rsp_clip_by
);

   typedef logic [COORD_BITS-1:0] coord_type;

   back_state_type state_ff, state_in;
   coord_type      ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   coord_type      rx_ff, rx_in, ry_ff, ry_in;
   pass_type       pass_ff, pass_in;
   logic           vis_ff, vis_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_visible_ff, rsp_visible_in;
   coord_type      rsp_ax_ff, rsp_ax_in, rsp_ay_ff, rsp_ay_in;
   coord_type      rsp_bx_ff, rsp_bx_in, rsp_by_ff, rsp_by_in;

   seg_class_type     pop_class;
   coord_type         pop_ax, pop_ay, pop_bx, pop_by;
   logic [3:0]        code_a, code_b, code_m;
   logic [COORD_BITS:0] sum_x, sum_y;
   coord_type         mid_x, mid_y, diff_x, diff_y;
   logic              far;
   logic              both_inside;
   logic              shared;
   logic              out_free;

   assign {pop_class, pop_ax, pop_ay, pop_bx, pop_by} = pop_data;

   assign code_a = outcode(COORD_BITS_MAX'(ax_ff), COORD_BITS_MAX'(ay_ff), window);
   assign code_b = outcode(COORD_BITS_MAX'(bx_ff), COORD_BITS_MAX'(by_ff), window);
   assign sum_x  = {1'b0, ax_ff} + {1'b0, bx_ff};
   assign sum_y  = {1'b0, ay_ff} + {1'b0, by_ff};
   assign mid_x  = sum_x[COORD_BITS:1];
   assign mid_y  = sum_y[COORD_BITS:1];
   assign code_m = outcode(COORD_BITS_MAX'(mid_x), COORD_BITS_MAX'(mid_y), window);
   assign diff_x = (ax_ff > bx_ff) ? ax_ff - bx_ff : bx_ff - ax_ff;
   assign diff_y = (ay_ff > by_ff) ? ay_ff - by_ff : by_ff - ay_ff;
   assign far    = (diff_x[COORD_BITS-1:1] != '0) || (diff_y[COORD_BITS-1:1] != '0);

   assign both_inside = (code_a == '0) && (code_b == '0);
   assign shared      = (code_a & code_b) != '0;
   assign out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!queue_status.empty) begin
               state_in = (pop_class == SEG_CLIP) ? BACK_CHECK : BACK_EMIT;
            end
         end
         BACK_CHECK: begin
            if (both_inside || shared || pass_ff == PASS_LAST) begin
               state_in = BACK_EMIT;
            end else if (code_b != '0) begin
               state_in = BACK_BISECT;
            end
         end
         BACK_BISECT: begin
            if (!far) begin
               state_in = BACK_CHECK;
            end
         end
         BACK_EMIT: begin
            if (out_free) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      pop            = 1'b0;
      ax_in          = ax_ff;
      ay_in          = ay_ff;
      bx_in          = bx_ff;
      by_in          = by_ff;
      rx_in          = rx_ff;
      ry_in          = ry_ff;
      pass_in        = pass_ff;
      vis_in         = vis_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_visible_in = rsp_visible_ff;
      rsp_ax_in      = rsp_ax_ff;
      rsp_ay_in      = rsp_ay_ff;
      rsp_bx_in      = rsp_bx_ff;
      rsp_by_in      = rsp_by_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!queue_status.empty) begin
               pop     = 1'b1;
               ax_in   = pop_ax;
               ay_in   = pop_ay;
               bx_in   = pop_bx;
               by_in   = pop_by;
               pass_in = PASS_FIRST;
               vis_in  = (pop_class == SEG_ACCEPT);
            end
         end
         BACK_CHECK: begin
            if (both_inside) begin
               vis_in = 1'b1;
            end else if (shared) begin
               vis_in = 1'b0;
            end else if (pass_ff == PASS_LAST) begin
               vis_in = 1'b1;
            end else if (code_b != '0) begin
               rx_in = ax_ff;
               ry_in = ay_ff;
            end else begin
               ax_in   = bx_ff;
               ay_in   = by_ff;
               bx_in   = ax_ff;
               by_in   = ay_ff;
               pass_in = pass_ff + 1'b1;
            end
         end
         BACK_BISECT: begin
            if (far) begin
               if ((code_m & code_b) != '0) begin
                  bx_in = mid_x;
                  by_in = mid_y;
               end else begin
                  ax_in = mid_x;
                  ay_in = mid_y;
               end
            end else begin
               ax_in   = bx_ff;
               ay_in   = by_ff;
               bx_in   = rx_ff;
               by_in   = ry_ff;
               pass_in = pass_ff + 1'b1;
            end
         end
         BACK_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_visible_in = vis_ff;
               rsp_ax_in      = vis_ff ? ax_ff : '0;
               rsp_ay_in      = vis_ff ? ay_ff : '0;
               rsp_bx_in      = vis_ff ? bx_ff : '0;
               rsp_by_in      = vis_ff ? by_ff : '0;
            end
         end
         default: pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff          <= ax_in;
      ay_ff          <= ay_in;
      bx_ff          <= bx_in;
      by_ff          <= by_in;
      rx_ff          <= rx_in;
      ry_ff          <= ry_in;
      pass_ff        <= pass_in;
      vis_ff         <= vis_in;
      rsp_visible_ff <= rsp_visible_in;
      rsp_ax_ff      <= rsp_ax_in;
      rsp_ay_ff      <= rsp_ay_in;
      rsp_bx_ff      <= rsp_bx_in;
      rsp_by_ff      <= rsp_by_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;
   assign rsp_clip_ax = rsp_ax_ff;
   assign rsp_clip_ay = rsp_ay_ff;
   assign rsp_clip_bx = rsp_bx_ff;
   assign rsp_clip_by = rsp_by_ff;

endmodule
`default_nettype wire

// ===== rtl/core/midpoint_subdivision_line_clipper.sv =====
// Clips one segment per request against the window held in four registers (x min at 0x0,
// x max at 0x4, y min at 0x8, y max at 0xC) by midpoint subdivision and returns a visible
// flag with the two clipped endpoints; a rejected segment returns all-zero endpoints. The
// front end classifies each request by outcodes and queues it, so requests are accepted
// while the back end works, as long as the queue is not full. A trivially accepted or rejected
// segment is loaded from the queue in the idle state and answered in the emit state. Any other
// segment also goes through up to three pass checks, up to COORD_BITS halvings per searched
// end and one swap of the ends after each search, with at most two searches. A stalled
// response holds the back end in its emit state until the previous response is taken.
`default_nettype none
module midpoint_subdivision_line_clipper
   import msc_pkg::*;
#(
   parameter int COORD_BITS  = COORD_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [COORD_BITS-1:0]    req_start_x,
   input  wire logic [COORD_BITS-1:0]    req_start_y,
   input  wire logic [COORD_BITS-1:0]    req_end_x,
   input  wire logic [COORD_BITS-1:0]    req_end_y,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_visible,
   output logic      [COORD_BITS-1:0]    rsp_clip_ax,
   output logic      [COORD_BITS-1:0]    rsp_clip_ay,
   output logic      [COORD_BITS-1:0]    rsp_clip_bx,
   output logic      [COORD_BITS-1:0]    rsp_clip_by,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready
);

   localparam int ITEM_BITS = 4 * COORD_BITS + $bits(seg_class_type);

   logic [COORD_BITS-1:0] win_x_min_ff, win_x_min_in;
   logic [COORD_BITS-1:0] win_x_max_ff, win_x_max_in;
   logic [COORD_BITS-1:0] win_y_min_ff, win_y_min_in;
   logic [COORD_BITS-1:0] win_y_max_ff, win_y_max_in;
   logic                  csr_write;
   csr_index_type         csr_index;
   window_type            window;
   queue_status_type      queue_status;
   logic                  push;
   logic                  pop;
   logic [ITEM_BITS-1:0]  push_data;
   logic [ITEM_BITS-1:0]  pop_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);

   always_comb begin
      win_x_min_in = win_x_min_ff;
      win_x_max_in = win_x_max_ff;
      win_y_min_in = win_y_min_ff;
      win_y_max_in = win_y_max_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_WIN_X_MIN: win_x_min_in = csr_pwdata[COORD_BITS-1:0];
            REG_WIN_X_MAX: win_x_max_in = csr_pwdata[COORD_BITS-1:0];
            REG_WIN_Y_MIN: win_y_min_in = csr_pwdata[COORD_BITS-1:0];
            REG_WIN_Y_MAX: win_y_max_in = csr_pwdata[COORD_BITS-1:0];
            default:       win_x_min_in = win_x_min_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_WIN_X_MIN: csr_prdata = CSR_DATA_BITS'(win_x_min_ff);
         REG_WIN_X_MAX: csr_prdata = CSR_DATA_BITS'(win_x_max_ff);
         REG_WIN_Y_MIN: csr_prdata = CSR_DATA_BITS'(win_y_min_ff);
         REG_WIN_Y_MAX: csr_prdata = CSR_DATA_BITS'(win_y_max_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_x_min_ff <= '0;
         win_x_max_ff <= {COORD_BITS{1'b1}};
         win_y_min_ff <= '0;
         win_y_max_ff <= {COORD_BITS{1'b1}};
      end else begin
         win_x_min_ff <= win_x_min_in;
         win_x_max_ff <= win_x_max_in;
         win_y_min_ff <= win_y_min_in;
         win_y_max_ff <= win_y_max_in;
      end
   end

   assign window.x_min = COORD_BITS_MAX'(win_x_min_ff);
   assign window.x_max = COORD_BITS_MAX'(win_x_max_ff);
   assign window.y_min = COORD_BITS_MAX'(win_y_min_ff);
   assign window.y_max = COORD_BITS_MAX'(win_y_max_ff);

   msc_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_start_x  (req_start_x),
      .req_start_y  (req_start_y),
      .req_end_x    (req_end_x),
      .req_end_y    (req_end_y),
      .window       (window),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   msc_queue #(
      .WIDTH (ITEM_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   msc_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .window       (window),
      .queue_status (queue_status),
      .pop_data     (pop_data),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_visible  (rsp_visible),
      .rsp_clip_ax  (rsp_clip_ax),
      .rsp_clip_ay  (rsp_clip_ay),
      .rsp_clip_bx  (rsp_clip_bx),
      .rsp_clip_by  (rsp_clip_by)
   );

endmodule
`default_nettype wire

// ===== rtl/core/msc_checker.sv =====
`default_nettype none
`include "midpoint_subdivision_line_clipper_macros.svh"
module msc_checker
   import msc_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic                     rsp_visible,
   input wire logic [COORD_BITS-1:0]    rsp_clip_ax,
   input wire logic [COORD_BITS-1:0]    rsp_clip_ay,
   input wire logic [COORD_BITS-1:0]    rsp_clip_bx,
   input wire logic [COORD_BITS-1:0]    rsp_clip_by,
   input wire logic                     csr_psel,
   input wire logic                     csr_penable,
   input wire logic                     csr_pwrite,
   input wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   input wire logic [CSR_DATA_BITS-1:0] csr_prdata,
   input wire logic                     csr_pready
);

   logic csr_write;

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   `MSC_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "response valid after reset")

   `MSC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_visible) && $stable(rsp_clip_ax) && $stable(rsp_clip_ay) && $stable(rsp_clip_bx) && $stable(rsp_clip_by), "stalled response changed")

   `MSC_ASSERT(a_reject_zero, clock, reset, rsp_valid && !rsp_visible |-> rsp_clip_ax == '0 && rsp_clip_ay == '0 && rsp_clip_bx == '0 && rsp_clip_by == '0, "rejected segment has nonzero endpoints")

   `MSC_ASSERT(a_csr_readback, clock, reset, $past(csr_write) && !$past(reset) && csr_paddr == $past(csr_paddr) |-> csr_prdata[COORD_BITS-1:0] == $past(csr_pwdata[COORD_BITS-1:0]), "register readback mismatch")

endmodule

bind midpoint_subdivision_line_clipper msc_checker #(
   .COORD_BITS (COORD_BITS)
) u_msc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_visible (rsp_visible),
   .rsp_clip_ax (rsp_clip_ax),
   .rsp_clip_ay (rsp_clip_ay),
   .rsp_clip_bx (rsp_clip_bx),
   .rsp_clip_by (rsp_clip_by),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata),
   .csr_pready  (csr_pready)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none
module tb_top;
   import msc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W    = COORD_BITS_DEFAULT;
   localparam int COORD_MAX  = (1 << COORD_W) - 1;
   localparam int IDLE_LIMIT = 3000;
   localparam int TAIL_WAIT  = 40;

   typedef logic [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic      visible;
      coord_type ax;
      coord_type ay;
      coord_type bx;
      coord_type by;
   } segment_clip_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   coord_type                req_start_x = '0;
   coord_type                req_start_y = '0;
   coord_type                req_end_x = '0;
   coord_type                req_end_y = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_visible;
   coord_type                rsp_clip_ax;
   coord_type                rsp_clip_ay;
   coord_type                rsp_clip_bx;
   coord_type                rsp_clip_by;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   coord_type win_x_lo = '0;
   coord_type win_x_hi = coord_type'(COORD_MAX);
   coord_type win_y_lo = '0;
   coord_type win_y_hi = coord_type'(COORD_MAX);

   segment_clip_type expected_clips[$];
   int               fail_count = 0;
   int               segments_sent = 0;
   int               clips_checked = 0;
   int               visible_seen = 0;
   int               windows_tried = 0;
   int               idle_cycles = 0;
   int               stall_mode = 0;
   int               stall_left = 0;
   int               stall_tick = 0;

   midpoint_subdivision_line_clipper u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_visible (rsp_visible),
      .rsp_clip_ax (rsp_clip_ax),
      .rsp_clip_ay (rsp_clip_ay),
      .rsp_clip_bx (rsp_clip_bx),
      .rsp_clip_by (rsp_clip_by),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [3:0] region_code(int unsigned x, int unsigned y);
      return {x < win_x_lo, x > win_x_hi, y < win_y_lo, y > win_y_hi};
   endfunction

   function automatic int unsigned span(int unsigned a, int unsigned b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic segment_clip_type clip_segment(coord_type sx, coord_type sy,
                                                     coord_type ex, coord_type ey);
      int unsigned      ax, ay, bx, by, rx, ry, mx, my;
      int               pass_no;
      logic [3:0]       ca, cb;
      logic             vis;
      logic             done;
      segment_clip_type r;
      ax = sx;
      ay = sy;
      bx = ex;
      by = ey;
      pass_no = 1;
      vis = 1'b0;
      done = 1'b0;
      while (!done) begin
         ca = region_code(ax, ay);
         cb = region_code(bx, by);
         rx = ax;
         ry = ay;
         if (ca == 4'd0 && cb == 4'd0) begin
            vis = 1'b1;
            done = 1'b1;
         end else if ((ca & cb) != 4'd0) begin
            vis = 1'b0;
            done = 1'b1;
         end else if (pass_no > 2) begin
            vis = 1'b1;
            done = 1'b1;
         end else begin
            if (cb != 4'd0) begin
               while (span(ax, bx) > 1 || span(ay, by) > 1) begin
                  mx = (ax + bx) >> 1;
                  my = (ay + by) >> 1;
                  if ((region_code(mx, my) & region_code(bx, by)) != 4'd0) begin
                     bx = mx;
                     by = my;
                  end else begin
                     ax = mx;
                     ay = my;
                  end
               end
            end
            ax = bx;
            ay = by;
            bx = rx;
            by = ry;
            pass_no++;
         end
      end
      r = '0;
      if (vis) begin
         r.visible = 1'b1;
         r.ax = coord_type'(ax);
         r.ay = coord_type'(ay);
         r.bx = coord_type'(bx);
         r.by = coord_type'(by);
      end
      return r;
   endfunction

   // favor window edges and extremes so most segments need real clipping
   function automatic coord_type pick_coord(int lo, int hi);
      int a, b, v;
      a = (lo < hi) ? lo : hi;
      b = (lo < hi) ? hi : lo;
      case ($urandom_range(0, 6))
         0, 1: v = $urandom_range(0, COORD_MAX);
         2: v = lo + $urandom_range(0, 8) - 4;
         3: v = hi + $urandom_range(0, 8) - 4;
         4: v = $urandom_range(0, 1) ? COORD_MAX : 0;
         default: v = $urandom_range(a, b);
      endcase
      if (v < 0) v = 0;
      if (v > COORD_MAX) v = COORD_MAX;
      return coord_type'(v);
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      segment_clip_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_clips.size() == 0) begin
            $display("%0t: unexpected response, expected none actual visible=%0d", $time,
                     rsp_visible);
            fail_count++;
         end else begin
            want = expected_clips.pop_front();
            check_field("visible", want.visible, rsp_visible);
            check_field("clip_ax", want.ax, rsp_clip_ax);
            check_field("clip_ay", want.ay, rsp_clip_ay);
            check_field("clip_bx", want.bx, rsp_clip_bx);
            check_field("clip_by", want.by, rsp_clip_by);
            clips_checked++;
            if (want.visible) visible_seen++;
         end
      end
   end

   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 80);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (stall_tick[2:0] != 3'd7);
      endcase
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d responses outstanding", $time,
                  idle_cycles, expected_clips.size());
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_segment(coord_type sx, coord_type sy, coord_type ex, coord_type ey);
      req_valid   <= 1'b1;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x   <= ex;
      req_end_y   <= ey;
      do @(posedge clock); while (!req_ready);
      expected_clips.insert(expected_clips.size(), clip_segment(sx, sy, ex, ey));
      segments_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_clips.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window_reg(csr_index_type idx, coord_type value);
      logic [CSR_DATA_BITS-1:0] data;
      data = $urandom();
      data[COORD_W-1:0] = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'(int'(idx) * 4);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_WIN_X_MIN: win_x_lo = value;
         REG_WIN_X_MAX: win_x_hi = value;
         REG_WIN_Y_MIN: win_y_lo = value;
         REG_WIN_Y_MAX: win_y_hi = value;
      endcase
   endtask

   task automatic set_window(int x_lo, int x_hi, int y_lo, int y_hi);
      wait_for_results();
      write_window_reg(REG_WIN_X_MIN, coord_type'(x_lo));
      write_window_reg(REG_WIN_X_MAX, coord_type'(x_hi));
      write_window_reg(REG_WIN_Y_MIN, coord_type'(y_lo));
      write_window_reg(REG_WIN_Y_MAX, coord_type'(y_hi));
      windows_tried++;
   endtask

   task automatic run_random_segments(int count, bit back_to_back);
      int        sent;
      int        burst;
      coord_type sx, sy, ex, ey;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < count; k++) begin
            sx = pick_coord(win_x_lo, win_x_hi);
            sy = pick_coord(win_y_lo, win_y_hi);
            ex = pick_coord(win_x_lo, win_x_hi);
            ey = pick_coord(win_y_lo, win_y_hi);
            if ($urandom_range(0, 15) == 0) begin
               ex = sx;
               ey = sy;
            end
            send_segment(sx, sy, ex, ey);
            sent++;
         end
         if (!back_to_back && $urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   endtask

   task automatic test_reset_window_extremes();
      send_segment(0, 0, COORD_MAX, COORD_MAX);
      send_segment(COORD_MAX, 0, 0, COORD_MAX);
      send_segment(0, 0, 0, 0);
      send_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      send_segment(11'h555, 11'h2AA, 11'h2AA, 11'h555);
   endtask

   task automatic test_window_cases();
      set_window(300, 1500, 400, 1200);
      send_segment(500, 500, 1000, 1000);
      send_segment(0, 500, 200, 900);
      send_segment(1600, 500, COORD_MAX, 1000);
      send_segment(500, 0, 900, 300);
      send_segment(500, 1300, 900, COORD_MAX);
      send_segment(100, 800, 800, 800);
      send_segment(800, 800, 2000, 800);
      send_segment(0, 0, COORD_MAX, COORD_MAX);
      send_segment(900, 0, 900, COORD_MAX);
      send_segment(0, 1000, 700, COORD_MAX);
      send_segment(0, 700, 700, 0);
      send_segment(100, 100, 100, 100);
      send_segment(1000, 1000, 1000, 1000);
      send_segment(300, 400, 1500, 1200);
      send_segment(COORD_MAX, 0, 0, COORD_MAX);
   endtask

   task automatic test_inverted_window();
      set_window(1500, 300, 1200, 400);
      send_segment(800, 800, 900, 900);
      send_segment(0, 0, COORD_MAX, COORD_MAX);
      send_segment(200, 1300, 1600, 100);
   endtask

   task automatic test_random_window();
      int a, b, c, d;
      a = $urandom_range(0, COORD_MAX);
      b = $urandom_range(0, COORD_MAX);
      c = $urandom_range(0, COORD_MAX);
      d = $urandom_range(0, COORD_MAX);
      set_window(a < b ? a : b, a < b ? b : a, c < d ? c : d, c < d ? d : c);
      run_random_segments(200, 1'b0);
   endtask

   task automatic test_full_window();
      set_window(0, COORD_MAX, 0, COORD_MAX);
      run_random_segments(100, 1'b1);
   endtask

   task automatic test_narrow_window();
      int x, y;
      x = $urandom_range(0, COORD_MAX);
      y = $urandom_range(0, COORD_MAX - 3);
      set_window(x, x, y, y + 3);
      run_random_segments(120, 1'b0);
   endtask

   task automatic test_corner_window();
      set_window(0, $urandom_range(200, 1800), $urandom_range(200, 1800), COORD_MAX);
      run_random_segments(130, 1'b1);
   endtask

   task automatic test_inverted_random();
      int a, b;
      a = $urandom_range(1, COORD_MAX);
      b = $urandom_range(1, COORD_MAX);
      set_window(a, $urandom_range(0, a - 1), b, $urandom_range(0, b - 1));
      run_random_segments(100, 1'b0);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_window_extremes();
      test_window_cases();
      test_inverted_window();
      test_random_window();
      test_full_window();
      test_narrow_window();
      test_corner_window();
      test_inverted_random();
      wait_for_results();
      repeat (TAIL_WAIT) @(posedge clock);
      $display("Clipped %0d segments over %0d window settings (reset window included).",
               segments_sent, windows_tried + 1);
      $display("%0d responses checked, %0d of them visible.", clips_checked, visible_seen);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
